// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define PRC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("prc assertion failed");

// checked on every edge, reset included
`define PRC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("prc assertion failed");

`endif

// ----- rtl/core/prc_pkg.sv -----
// ----------------------------------------------------------------------------
// prc_pkg
// types, constants and arithmetic helpers of the rotation stream cipher
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int unsigned SeedW    = 17;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned AmountW  = 7;
  localparam int unsigned ProdW    = 24;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  localparam logic [ProdW-1:0]   Multiplier = 24'd75;
  localparam logic [SeedW:0]     Modulus    = 18'd65537;
  localparam logic [ByteW-1:0]   PrintLo    = 8'd32;
  localparam logic [ByteW-1:0]   PrintSpan  = 8'd96;

  // register index codes, taken from paddr[2]
  localparam logic RegStartSeed = 1'b0;
  localparam logic RegDirection = 1'b1;

  localparam logic DirEncrypt = 1'b0;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [SeedW-1:0] seed;
  } prc_entry_t;

  typedef struct packed {
    logic       push;
    prc_entry_t entry;
  } prc_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } prc_qstat_t;

  // seed * 75 mod 65537 by folding the product
  function automatic logic [SeedW-1:0] advance_seed(input logic [SeedW-1:0] s);
    logic [ProdW-1:0] prod;
    logic [SeedW:0]   diff;
    prod = ProdW'(s) * Multiplier;
    diff = {2'b00, prod[15:0]} - {10'b0, prod[23:16]};
    if (diff[SeedW]) begin
      diff = diff + Modulus;
    end
    return diff[SeedW-1:0];
  endfunction

  // seed mod 96 as ((seed >> 5) mod 3) * 32 + seed[4:0]
  function automatic logic [AmountW-1:0] seed_mod96(input logic [SeedW-1:0] s);
    logic [4:0] sum;
    sum = 5'(s[6:5]) + 5'(s[8:7]) + 5'(s[10:9]) + 5'(s[12:11])
        + 5'(s[14:13]) + 5'(s[16:15]);
    if (sum >= 5'd12) begin
      sum = sum - 5'd12;
    end
    if (sum >= 5'd6) begin
      sum = sum - 5'd6;
    end
    if (sum >= 5'd3) begin
      sum = sum - 5'd3;
    end
    return {sum[1:0], s[4:0]};
  endfunction

  function automatic logic [ByteW-1:0] rotate_byte(input logic [ByteW-1:0]   c,
                                                   input logic [AmountW-1:0] k,
                                                   input logic               dir);
    logic [ByteW-1:0] pos;
    logic [ByteW-1:0] t;
    pos = c - PrintLo;
    if (dir == DirEncrypt) begin
      t = pos + {1'b0, k};
      if (t >= PrintSpan) begin
        t = t - PrintSpan;
      end
    end else begin
      t = pos - {1'b0, k};
      if (t[ByteW-1]) begin
        t = t + PrintSpan;
      end
    end
    if (c[7] || (c[6:5] == 2'b00)) begin
      return c;
    end
    return t + PrintLo;
  endfunction

endpackage

// ----- rtl/core/prc_if.sv -----
// ----------------------------------------------------------------------------
// prc_in_if / prc_out_if
// valid/ready channels for input bytes and cipher results
// ----------------------------------------------------------------------------
interface prc_in_if;
  logic                          valid;
  logic                          ready;
  logic [prc_pkg::ByteW-1:0]     data_byte;
  logic                          first_of_message;

  modport source (output valid, data_byte, first_of_message, input ready);
  modport sink   (input valid, data_byte, first_of_message, output ready);
endinterface

interface prc_out_if;
  logic                          valid;
  logic                          ready;
  logic [prc_pkg::ByteW-1:0]     out_byte;

  modport source (output valid, out_byte, input ready);
  modport sink   (input valid, out_byte, output ready);
endinterface

// ----- rtl/core/prng_rotation_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// prng_rotation_stream_cipher
// lehmer mod 65537 seeded rotation cipher over printable ascii
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        data_byte[7:0], first_of_message
//   out_ch   out  valid/ready        out_byte[7:0]
//   apb      in   psel/penable       paddr[2:0], pwdata/prdata[31:0]
//
// one byte per cycle while out_ch.ready holds; queue entry, then output register
// front end advances the seed in the accept cycle, back end rotates from queue
// two-entry queue plus output register let either side stall on its own
// in_ch.ready drops only when the queue is full behind a stalled output
// synchronous reset, no clearing pass
// ----------------------------------------------------------------------------
module prng_rotation_stream_cipher (
  input  logic                        clk,
  input  logic                        rst_n,
  prc_in_if.sink                      in_ch,
  prc_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prc_pkg::AddrW-1:0]   paddr,
  input  logic [prc_pkg::DataW-1:0]   pwdata,
  output logic [prc_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  logic [prc_pkg::SeedW-1:0] start_seed;
  logic                      direction;
  prc_pkg::prc_push_t        push;
  prc_pkg::prc_qstat_t       qstat;
  prc_pkg::prc_entry_t       head;
  logic                      pop;

  prc_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start_seed (start_seed),
    .direction  (direction)
  );

  prc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .start_seed (start_seed),
    .qstat      (qstat),
    .push       (push)
  );

  prc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .qstat (qstat),
    .head  (head)
  );

  prc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .head      (head),
    .direction (direction),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

// ----- rtl/core/prc_cfg.sv -----
// ----------------------------------------------------------------------------
// prc_cfg
// apb register file: start seed and direction
// ----------------------------------------------------------------------------
module prc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prc_pkg::AddrW-1:0]   paddr,
  input  logic [prc_pkg::DataW-1:0]   pwdata,
  output logic [prc_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output logic [prc_pkg::SeedW-1:0]   start_seed,
  output logic                        direction
);

  logic [prc_pkg::SeedW-1:0] start_seed_r;
  logic                      direction_r;
  logic                      wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_seed_r <= '0;
      direction_r  <= 1'b1;
    end else if (wr_en) begin
      case (paddr[2])
        prc_pkg::RegStartSeed: start_seed_r <= pwdata[prc_pkg::SeedW-1:0];
        prc_pkg::RegDirection: direction_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      prc_pkg::RegStartSeed: prdata = prc_pkg::DataW'(start_seed_r);
      prc_pkg::RegDirection: prdata = prc_pkg::DataW'(direction_r);
      default:               prdata = '0;
    endcase
  end

  assign start_seed = start_seed_r;
  assign direction  = direction_r;

endmodule

// ----- rtl/core/prc_front.sv -----
// ----------------------------------------------------------------------------
// prc_front
// accepts bytes, reloads and advances the lehmer seed, pushes to the queue
// ----------------------------------------------------------------------------
module prc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  prc_in_if.sink                     in_ch,
  input  logic [prc_pkg::SeedW-1:0]  start_seed,
  input  prc_pkg::prc_qstat_t        qstat,
  output prc_pkg::prc_push_t         push
);

  logic [prc_pkg::SeedW-1:0] seed_r;
  logic [prc_pkg::SeedW-1:0] seed_nxt;
  logic                      accept;

  assign in_ch.ready = ~qstat.full;
  assign accept      = in_ch.valid & ~qstat.full;
  assign seed_nxt    = prc_pkg::advance_seed(in_ch.first_of_message ? start_seed : seed_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (accept) begin
      seed_r <= seed_nxt;
    end
  end

  assign push.push            = accept;
  assign push.entry.data_byte = in_ch.data_byte;
  assign push.entry.seed      = seed_nxt;

endmodule

// ----- rtl/core/prc_queue.sv -----
// ----------------------------------------------------------------------------
// prc_queue
// two-entry queue between seed front end and rotation back end
// ----------------------------------------------------------------------------
module prc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  prc_pkg::prc_push_t    push,
  input  logic                  pop,
  output prc_pkg::prc_qstat_t   qstat,
  output prc_pkg::prc_entry_t   head
);

  prc_pkg::prc_entry_t mem_r [2];
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          count_r;
  logic                do_pop;

  assign do_pop = pop & (count_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push.push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push.push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push.push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  assign head        = mem_r[rd_ptr_r];
  assign qstat.full  = count_r[1];
  assign qstat.empty = (count_r == 2'd0);

endmodule

// ----- rtl/core/prc_back.sv -----
// ----------------------------------------------------------------------------
// prc_back
// rotates printable bytes by seed mod 96 into the output register
// ----------------------------------------------------------------------------
module prc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  prc_pkg::prc_qstat_t   qstat,
  input  prc_pkg::prc_entry_t   head,
  input  logic                  direction,
  output logic                  pop,
  prc_out_if.source             out_ch
);

  logic                      out_valid_r;
  logic [prc_pkg::ByteW-1:0] out_byte_r;
  logic [prc_pkg::ByteW-1:0] out_byte_nxt;

  assign pop          = ~qstat.empty & (~out_valid_r | out_ch.ready);
  assign out_byte_nxt = prc_pkg::rotate_byte(head.data_byte,
                                             prc_pkg::seed_mod96(head.seed), direction);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte_r <= out_byte_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;

endmodule

// ----- rtl/core/prc_checker.sv -----
// ----------------------------------------------------------------------------
// prc_checker
// port-level assertions for the rotation stream cipher
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [prc_pkg::ByteW-1:0]  out_byte,
  input logic                       pready
);

  // output held while stalled
  `PRC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte))
  // input backpressure only behind a waiting result
  `PRC_ASSERT(a_bp_needs_out, clk, rst_n, !in_ready |-> out_valid)
  // no result and input ready right after reset
  `PRC_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_valid && in_ready)
  // no wait states on the register port
  `PRC_ASSERT(a_pready, clk, rst_n, pready)

endmodule

bind prng_rotation_stream_cipher prc_checker u_prc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .pready    (pready)
);

// ----- tb/sv/prng_rotation_stream_cipher_test.sv -----
// ----------------------------------------------------------------------------
// prng_rotation_stream_cipher_test
// Self-checking testbench for the rotation stream cipher. A queue-fed driver
// sends character bytes in random bursts while the receiver stalls on its own
// pattern. Each accepted byte is enciphered by a local predictor (mod 65537
// seed generator plus printable-range rotation), and every output
// transaction is compared against the oldest predicted byte. Several seed
// and direction settings are written over the APB port between phases.
// ----------------------------------------------------------------------------
module prng_rotation_stream_cipher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PrintFirst = 32;
  localparam int unsigned PrintCount = 96;
  localparam logic [prc_pkg::AddrW-1:0] SeedAddr = {prc_pkg::RegStartSeed, 2'b00};
  localparam logic [prc_pkg::AddrW-1:0] DirAddr  = {prc_pkg::RegDirection, 2'b00};

  typedef struct packed {
    logic [prc_pkg::ByteW-1:0] data_byte;
    logic                      msg_start;
  } char_item_t;

  typedef enum int {StallNone, StallRandom, StallPattern} stall_mode_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [prc_pkg::AddrW-1:0] paddr = '0;
  logic [prc_pkg::DataW-1:0] pwdata = '0;
  logic [prc_pkg::DataW-1:0] prdata;
  logic                      pready;

  logic                      drv_valid = 1'b0;
  logic [prc_pkg::ByteW-1:0] drv_data = '0;
  logic                      drv_first = 1'b0;
  logic                      drv_ready = 1'b0;

  char_item_t                pending_chars[$];
  logic [prc_pkg::ByteW-1:0] expected_bytes[$];

  logic [prc_pkg::SeedW-1:0] cfg_seed = '0;
  logic                      cfg_dir = 1'b1;
  logic [prc_pkg::SeedW-1:0] seed_now = '0;

  bit               in_accepted = 1'b0;
  int unsigned      mismatches = 0;
  int unsigned      burst_left = 1;
  int unsigned      gap_left = 0;
  int unsigned      stall_left = 0;
  int unsigned      stall_phase = 0;
  logic [31:0]      stall_pat = '1;
  stall_mode_t      stall_mode = StallNone;

  prc_in_if  in_ch();
  prc_out_if out_ch();

  assign in_ch.valid            = drv_valid;
  assign in_ch.data_byte        = drv_data;
  assign in_ch.first_of_message = drv_first;
  assign out_ch.ready           = drv_ready;

  prng_rotation_stream_cipher u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [prc_pkg::SeedW-1:0] lehmer_next(
      input logic [prc_pkg::SeedW-1:0] s);
    logic [23:0] prod;
    logic [16:0] lo;
    logic [16:0] hi;
    prod = 24'(s) * 24'd75;
    lo   = {1'b0, prod[15:0]};
    hi   = {9'b0, prod[23:16]};
    if (lo >= hi) begin
      return lo - hi;
    end
    return 17'd65537 - (hi - lo);
  endfunction

  function automatic logic [prc_pkg::ByteW-1:0] rotated(
      input logic [prc_pkg::ByteW-1:0] c,
      input logic [prc_pkg::SeedW-1:0] s,
      input logic dir);
    int unsigned k;
    int unsigned pos;
    k = s % PrintCount;
    if (c < PrintFirst || c >= PrintFirst + PrintCount) begin
      return c;
    end
    pos = c - PrintFirst;
    if (dir == prc_pkg::DirEncrypt) begin
      pos = (pos + k) % PrintCount;
    end else begin
      pos = (pos + PrintCount - k) % PrintCount;
    end
    return 8'(pos + PrintFirst);
  endfunction

  function automatic logic [prc_pkg::ByteW-1:0] cipher_next(
      input logic [prc_pkg::ByteW-1:0] c,
      input logic first);
    if (first) begin
      seed_now = cfg_seed;
    end
    seed_now = lehmer_next(seed_now);
    return rotated(c, seed_now, cfg_dir);
  endfunction

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (drv_valid && !in_accepted) begin
      // hold until taken
    end else if (gap_left != 0) begin
      drv_valid <= 1'b0;
      gap_left = gap_left - 1;
    end else if (pending_chars.size() != 0) begin
      drv_valid <= 1'b1;
      drv_data  <= pending_chars[0].data_byte;
      drv_first <= pending_chars[0].msg_start;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left = burst_left - 1;
      end
    end else begin
      drv_valid <= 1'b0;
    end
  end

  // output stall pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_pat  = $urandom | 32'h1;
      stall_left = $urandom_range(20, 80);
    end else begin
      stall_left = stall_left - 1;
    end
    stall_phase = stall_phase + 1;
    case (stall_mode)
      StallNone: begin
        drv_ready <= 1'b1;
      end
      StallRandom: begin
        drv_ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        drv_ready <= stall_pat[stall_phase % 32];
      end
    endcase
  end

  // monitor and checker
  always @(posedge clk) begin
    logic [prc_pkg::ByteW-1:0] want;
    in_accepted = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: expected none, actual %0d", out_ch.out_byte);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_ch.out_byte !== want) begin
            $error("out_byte: expected %0d, actual %0d", want, out_ch.out_byte);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        in_accepted = 1'b1;
        expected_bytes.push_back(cipher_next(in_ch.data_byte, in_ch.first_of_message));
        void'(pending_chars.pop_front());
      end
    end
  end

  task automatic add_char(input logic [prc_pkg::ByteW-1:0] b, input logic first);
    char_item_t item;
    item.data_byte = b;
    item.msg_start = first;
    pending_chars.push_back(item);
  endtask

  task automatic wait_idle();
    while (pending_chars.size() != 0 || expected_bytes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [prc_pkg::AddrW-1:0] addr,
                           input logic [prc_pkg::DataW-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    if (addr[2] == prc_pkg::RegDirection) begin
      cfg_dir = value[0];
    end else begin
      cfg_seed = value[prc_pkg::SeedW-1:0];
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic random_traffic(input int unsigned count, input bit pause_half);
    int unsigned sent;
    int unsigned len;
    int unsigned i;
    bit          pause_due;
    logic [prc_pkg::ByteW-1:0] b;
    sent      = 0;
    pause_due = pause_half;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len = $urandom_range(1, 40);
        for (i = 0; i < len && sent < count; i++) begin
          if ($urandom_range(0, 9) < 8) begin
            b = 8'($urandom_range(32, 127));
          end else begin
            b = 8'($urandom_range(0, 255));
          end
          add_char(b, i == 0);
          sent++;
        end
      end
      if (pause_due && sent >= count / 2) begin
        pause_due = 1'b0;
        wait_idle();
      end
    end
    wait_idle();
  endtask

  initial begin
    int unsigned p;
    logic [prc_pkg::SeedW-1:0] s;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset defaults, first bytes sent without a start flag
    add_char(8'd65, 1'b0);
    add_char(8'd127, 1'b0);
    add_char(8'd32, 1'b1);
    wait_idle();

    write_reg(SeedAddr, 32'd1);
    write_reg(DirAddr, 32'd0);
    add_char(8'd32, 1'b1);
    add_char(8'd127, 1'b0);
    add_char(8'd0, 1'b0);
    add_char(8'd31, 1'b0);
    add_char(8'd128, 1'b0);
    add_char(8'd255, 1'b0);
    add_char(8'd65, 1'b0);
    wait_idle();

    write_reg(SeedAddr, 32'd131071);
    write_reg(DirAddr, 32'd1);
    add_char(8'd122, 1'b1);
    add_char(8'd32, 1'b0);
    add_char(8'd127, 1'b0);
    add_char(8'd100, 1'b0);
    wait_idle();

    write_reg(SeedAddr, 32'd65536);
    write_reg(DirAddr, 32'd0);
    add_char(8'd64, 1'b1);
    add_char(8'd126, 1'b0);
    add_char(8'd33, 1'b0);
    wait_idle();

    write_reg(SeedAddr, 32'd65537);
    add_char(8'd90, 1'b1);
    add_char(8'd91, 1'b0);
    wait_idle();

    for (p = 0; p < 6; p++) begin
      case (p)
        0:       s = 17'd131071;
        1:       s = 17'd0;
        2:       s = 17'd65536;
        default: s = 17'($urandom_range(0, 131071));
      endcase
      write_reg(SeedAddr, 32'(s));
      write_reg(DirAddr, (p < 4) ? 32'(p % 2) : 32'($urandom_range(0, 1)));
      random_traffic(108, p == 3);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- prng_rotation_stream_cipher.f -----
+incdir+rtl/core
rtl/core/prc_pkg.sv
rtl/core/prc_if.sv
rtl/core/prc_cfg.sv
rtl/core/prc_front.sv
rtl/core/prc_queue.sv
rtl/core/prc_back.sv
rtl/core/prng_rotation_stream_cipher.sv
rtl/core/prc_checker.sv
tb/sv/prng_rotation_stream_cipher_test.sv
